[rtl/ticket_deque_with_search_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ticket deque
// Shared concurrent check forms for the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef TICKET_DEQUE_WITH_SEARCH_MACROS_SVH
`define TICKET_DEQUE_WITH_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tdq_pkg.sv]
// ----------------------------------------------------------------------------
// Ticket deque package
// Sizes, request and result codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TICKET_BITS = 16;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Fixed field widths on the ports.
   localparam int OPCODE_W      = 3;
   localparam int TICKET_W      = 16;
   localparam int TIME_W        = 17;
   localparam int STATUS_W      = 2;
   localparam int POS_OUT_W     = 4;
   localparam int COUNT_OUT_W   = 5;
   localparam int REQ_TDATA_W   = 40;
   localparam int REQ_TUSER_W   = 3;
   localparam int RSP_TDATA_W   = 48;
   localparam int RSP_TUSER_W   = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR     = 3'd0,
      OP_PUSH      = 3'd1,
      OP_POP_HEAD  = 3'd2,
      OP_POP_TAIL  = 3'd3,
      OP_PEEK      = 3'd4,
      OP_SEARCH    = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Commands from the controller; at most one is active in a cycle.
   typedef struct packed {
      logic capture;
      logic finish_direct;
      logic fetch_end;
      logic take_entry;
      logic scan_start;
      logic scan_next;
      logic scan_found;
      logic scan_miss;
      logic publish;
   } cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       empty;
      logic       scan_match;
      logic       scan_last;
   } stat_type;

endpackage

[rtl/tdq_datapath.sv]
// ----------------------------------------------------------------------------
// Ticket deque datapath
// Entry memory, head and fill count, scan position and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ticket_deque_with_search_macros.svh"

module tdq_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  tdq_pkg::cmd_type                    cmd,
   output tdq_pkg::stat_type                   stat,
   input  logic [tdq_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [tdq_pkg::TICKET_W-1:0]        req_ticket,
   input  logic [tdq_pkg::TIME_W-1:0]          req_issue_time,
   output logic [tdq_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_entry_valid,
   output logic [tdq_pkg::TICKET_W-1:0]        rsp_entry_ticket,
   output logic [tdq_pkg::TIME_W-1:0]          rsp_entry_time,
   output logic [tdq_pkg::POS_OUT_W-1:0]       rsp_entry_position,
   output logic [tdq_pkg::COUNT_OUT_W-1:0]     rsp_fill_count,
   output logic                                rsp_is_empty
);

   localparam int IDX_W   = tdq_pkg::IDX_W;
   localparam int CNT_W   = tdq_pkg::CNT_W;
   localparam int TK_W    = tdq_pkg::TICKET_BITS;
   localparam int TM_W    = tdq_pkg::TIME_W;
   localparam int WORD_W  = TK_W + TM_W;

   // Circular index: base plus an offset of at most the depth, folded once.
   function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (sum >= (CNT_W + 1)'(tdq_pkg::QUEUE_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(tdq_pkg::QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [WORD_W-1:0]        mem [tdq_pkg::QUEUE_DEPTH];
   logic [WORD_W-1:0]        rd_ff;
   logic                     mem_we;
   logic                     mem_re;
   logic [IDX_W-1:0]         wr_addr;
   logic [IDX_W-1:0]         rd_addr;

   tdq_pkg::opcode_type      op_ff, op_in;
   logic [TK_W-1:0]          key_ff, key_in;
   logic [TM_W-1:0]          time_ff, time_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         scan_pos_ff, scan_pos_in;

   tdq_pkg::status_type      pend_status_ff, pend_status_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [TK_W-1:0]          pend_ticket_ff, pend_ticket_in;
   logic [TM_W-1:0]          pend_time_ff, pend_time_in;
   logic [IDX_W-1:0]         pend_pos_ff, pend_pos_in;

   logic [tdq_pkg::STATUS_W-1:0]    out_status_ff, out_status_in;
   logic                            out_valid_ff, out_valid_in;
   logic [tdq_pkg::TICKET_W-1:0]    out_ticket_ff, out_ticket_in;
   logic [tdq_pkg::TIME_W-1:0]      out_time_ff, out_time_in;
   logic [tdq_pkg::POS_OUT_W-1:0]   out_pos_ff, out_pos_in;
   logic [tdq_pkg::COUNT_OUT_W-1:0] out_fill_ff, out_fill_in;
   logic                            out_empty_ff, out_empty_in;

   logic [TK_W-1:0]          rd_ticket;
   logic [TM_W-1:0]          rd_time;
   logic [CNT_W-1:0]         tail_off;
   logic [CNT_W-1:0]         scan_off;
   logic                     is_full;

   assign rd_ticket = rd_ff[TK_W-1:0];
   assign rd_time   = rd_ff[TK_W +: TM_W];
   assign tail_off  = count_ff - 1'b1;
   assign scan_off  = CNT_W'(scan_pos_ff) + 1'b1;
   assign is_full   = (count_ff == CNT_W'(tdq_pkg::QUEUE_DEPTH));
   assign wr_addr   = slot_add(head_ff, count_ff);

   assign stat.opcode     = op_ff;
   assign stat.empty      = (count_ff == '0);
   assign stat.scan_match = (rd_ticket == key_ff);
   assign stat.scan_last  = (CNT_W'(scan_pos_ff) == tail_off);

   always_comb begin
      op_in          = op_ff;
      key_in         = key_ff;
      time_in        = time_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      scan_pos_in    = scan_pos_ff;
      pend_status_in = pend_status_ff;
      pend_valid_in  = pend_valid_ff;
      pend_ticket_in = pend_ticket_ff;
      pend_time_in   = pend_time_ff;
      pend_pos_in    = pend_pos_ff;
      out_status_in  = out_status_ff;
      out_valid_in   = out_valid_ff;
      out_ticket_in  = out_ticket_ff;
      out_time_in    = out_time_ff;
      out_pos_in     = out_pos_ff;
      out_fill_in    = out_fill_ff;
      out_empty_in   = out_empty_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      rd_addr        = head_ff;

      if (cmd.capture) begin
         op_in   = tdq_pkg::opcode_type'(req_opcode);
         key_in  = TK_W'(req_ticket);
         time_in = req_issue_time;
      end

      // Requests that finish without reading the memory.
      if (cmd.finish_direct) begin
         pend_status_in = tdq_pkg::ST_OK;
         pend_valid_in  = 1'b0;
         pend_ticket_in = '0;
         pend_time_in   = '0;
         pend_pos_in    = '0;
         case (op_ff)
            tdq_pkg::OP_CLEAR: begin
               head_in  = '0;
               count_in = '0;
            end
            tdq_pkg::OP_PUSH: begin
               if (is_full) begin
                  pend_status_in = tdq_pkg::ST_FULL;
               end else begin
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            tdq_pkg::OP_POP_HEAD, tdq_pkg::OP_POP_TAIL, tdq_pkg::OP_PEEK: begin
               pend_status_in = tdq_pkg::ST_EMPTY;
            end
            tdq_pkg::OP_SEARCH: begin
               pend_status_in = tdq_pkg::ST_NOT_FOUND;
            end
            default: begin
            end
         endcase
      end

      if (cmd.fetch_end) begin
         mem_re = 1'b1;
         if (op_ff == tdq_pkg::OP_POP_TAIL) begin
            rd_addr     = slot_add(head_ff, tail_off);
            pend_pos_in = tail_off[IDX_W-1:0];
         end else begin
            pend_pos_in = '0;
         end
      end

      if (cmd.take_entry) begin
         pend_status_in = tdq_pkg::ST_OK;
         pend_valid_in  = 1'b1;
         pend_ticket_in = rd_ticket;
         pend_time_in   = rd_time;
         if (op_ff == tdq_pkg::OP_POP_HEAD) begin
            count_in = tail_off;
            head_in  = (tail_off == '0) ? '0 : slot_add(head_ff, CNT_W'(1));
         end else if (op_ff == tdq_pkg::OP_POP_TAIL) begin
            count_in = tail_off;
            if (tail_off == '0) begin
               head_in = '0;
            end
         end
      end

      if (cmd.scan_start) begin
         mem_re      = 1'b1;
         rd_addr     = head_ff;
         scan_pos_in = '0;
      end

      // The next read goes out while the current word is compared.
      if (cmd.scan_next) begin
         mem_re      = 1'b1;
         rd_addr     = slot_add(head_ff, scan_off);
         scan_pos_in = scan_pos_ff + 1'b1;
      end

      if (cmd.scan_found) begin
         pend_status_in = tdq_pkg::ST_OK;
         pend_valid_in  = 1'b1;
         pend_ticket_in = rd_ticket;
         pend_time_in   = rd_time;
         pend_pos_in    = scan_pos_ff;
      end

      if (cmd.scan_miss) begin
         pend_status_in = tdq_pkg::ST_NOT_FOUND;
         pend_valid_in  = 1'b0;
         pend_ticket_in = '0;
         pend_time_in   = '0;
         pend_pos_in    = '0;
      end

      if (cmd.publish) begin
         out_status_in = pend_status_ff;
         out_valid_in  = pend_valid_ff;
         out_ticket_in = tdq_pkg::TICKET_W'(pend_ticket_ff);
         out_time_in   = pend_time_ff;
         out_pos_in    = tdq_pkg::POS_OUT_W'(pend_pos_ff);
         out_fill_in   = tdq_pkg::COUNT_OUT_W'(count_ff);
         out_empty_in  = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= {time_ff, key_ff};
      end
      if (mem_re) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      time_ff        <= time_in;
      scan_pos_ff    <= scan_pos_in;
      pend_status_ff <= pend_status_in;
      pend_valid_ff  <= pend_valid_in;
      pend_ticket_ff <= pend_ticket_in;
      pend_time_ff   <= pend_time_in;
      pend_pos_ff    <= pend_pos_in;
      out_status_ff  <= out_status_in;
      out_valid_ff   <= out_valid_in;
      out_ticket_ff  <= out_ticket_in;
      out_time_ff    <= out_time_in;
      out_pos_ff     <= out_pos_in;
      out_fill_ff    <= out_fill_in;
      out_empty_ff   <= out_empty_in;
   end

   assign rsp_status         = out_status_ff;
   assign rsp_entry_valid    = out_valid_ff;
   assign rsp_entry_ticket   = out_ticket_ff;
   assign rsp_entry_time     = out_time_ff;
   assign rsp_entry_position = out_pos_ff;
   assign rsp_fill_count     = out_fill_ff;
   assign rsp_is_empty       = out_empty_ff;

   `TDQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(tdq_pkg::QUEUE_DEPTH), "fill count above depth")
   `TDQ_ASSERT_NOW(a_head_home, clock, reset, count_ff == '0, head_ff == '0, "empty queue with head off slot zero")
   `TDQ_ASSERT_NOW(a_scan_bound, clock, reset, cmd.scan_next, CNT_W'(scan_pos_ff) < tail_off, "scan read past the tail")

endmodule

[rtl/tdq_ctrl.sv]
// ----------------------------------------------------------------------------
// Ticket deque controller
// Sequences one request through decode, memory read or scan, and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ticket_deque_with_search_macros.svh"

module tdq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  tdq_pkg::stat_type  stat,
   output tdq_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FETCH,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.opcode)
               tdq_pkg::OP_POP_HEAD, tdq_pkg::OP_POP_TAIL, tdq_pkg::OP_PEEK: begin
                  if (stat.empty) begin
                     cmd.finish_direct = 1'b1;
                     state_in          = ST_DONE;
                  end else begin
                     cmd.fetch_end = 1'b1;
                     state_in      = ST_FETCH;
                  end
               end
               tdq_pkg::OP_SEARCH: begin
                  if (stat.empty) begin
                     cmd.finish_direct = 1'b1;
                     state_in          = ST_DONE;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               default: begin
                  cmd.finish_direct = 1'b1;
                  state_in          = ST_DONE;
               end
            endcase
         end
         ST_FETCH: begin
            cmd.take_entry = 1'b1;
            state_in       = ST_DONE;
         end
         ST_SCAN: begin
            if (stat.scan_match) begin
               cmd.scan_found = 1'b1;
               state_in       = ST_DONE;
            end else if (stat.scan_last) begin
               cmd.scan_miss = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_DONE: begin
            // Wait here until the result register is free or being emptied.
            if (slot_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TDQ_ASSERT_NOW(a_cmd_single, clock, reset, 1'b1, $onehot0(cmd), "more than one datapath command")
   `TDQ_ASSERT_NEXT(a_accept_decode, clock, reset, req_tvalid && req_tready, state_ff == ST_DECODE, "accepted request not decoded")
   `TDQ_ASSERT_NEXT(a_publish_shows, clock, reset, cmd.publish, rsp_valid_ff && state_ff == ST_IDLE, "published result not presented")

endmodule

[rtl/ticket_deque_with_search.sv]
// ----------------------------------------------------------------------------
// Ticket deque with search
// Bounded double-ended queue of service tickets with head-to-tail search.
// ----------------------------------------------------------------------------
// Each request takes one result. Clear, push, unused opcodes and any request
// on an empty queue go from decode straight to the result; pop head, pop
// tail and peek pass through a fetch state; a search reads from the head
// until it hits or reaches the last entry. A new request is taken only once
// the last result has moved to the output register. The entry memory has a
// registered read, which the search walks one entry per cycle while the next
// read is already out. A finished result waits in the output register while
// the next request is worked on.
`timescale 1ns / 1ps

module ticket_deque_with_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] ticket, [32:16] issue_time, [39:33] zero
   input  logic [tdq_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [2:0] opcode
   input  logic [tdq_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] entry_ticket, [32:16] entry_time, [36:33] entry_position,
   // [41:37] fill_count, [42] is_empty, [47:43] zero
   output logic [tdq_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [1:0] status, [2] entry_valid
   output logic [tdq_pkg::RSP_TUSER_W-1:0]     rsp_tuser
);

   tdq_pkg::cmd_type                 cmd;
   tdq_pkg::stat_type                stat;
   logic [tdq_pkg::STATUS_W-1:0]     rsp_status;
   logic                             rsp_entry_valid;
   logic [tdq_pkg::TICKET_W-1:0]     rsp_entry_ticket;
   logic [tdq_pkg::TIME_W-1:0]       rsp_entry_time;
   logic [tdq_pkg::POS_OUT_W-1:0]    rsp_entry_position;
   logic [tdq_pkg::COUNT_OUT_W-1:0]  rsp_fill_count;
   logic                             rsp_is_empty;

   tdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tdq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_opcode         (req_tuser[2:0]),
      .req_ticket         (req_tdata[15:0]),
      .req_issue_time     (req_tdata[32:16]),
      .rsp_status         (rsp_status),
      .rsp_entry_valid    (rsp_entry_valid),
      .rsp_entry_ticket   (rsp_entry_ticket),
      .rsp_entry_time     (rsp_entry_time),
      .rsp_entry_position (rsp_entry_position),
      .rsp_fill_count     (rsp_fill_count),
      .rsp_is_empty       (rsp_is_empty)
   );

   assign rsp_tdata = {5'd0, rsp_is_empty, rsp_fill_count, rsp_entry_position,
                       rsp_entry_time, rsp_entry_ticket};
   assign rsp_tuser = {rsp_entry_valid, rsp_status};

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Ticket deque regression bench
// A queue-fed driver and a clocked monitor run the deque over a short
// directed sequence and then push, pop, peek and search bursts with random
// tickets. Four phases vary idling on the request and response sides. An
// in-bench deque model predicts each response, and the monitor checks every
// response field against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam logic [tdq_pkg::OPCODE_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [tdq_pkg::OPCODE_W-1:0] OP_SPARE_B = 3'd7;
   localparam int MAX_TIME    = 86399;
   localparam int PHASE_ITEMS = 270;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [tdq_pkg::OPCODE_W-1:0] opcode;
      logic [tdq_pkg::TICKET_W-1:0] ticket;
      logic [tdq_pkg::TIME_W-1:0]   issue_sec;
   } ticket_request_type;

   typedef struct packed {
      tdq_pkg::status_type              status;
      logic                             entry_valid;
      logic [tdq_pkg::TICKET_W-1:0]     ticket;
      logic [tdq_pkg::TIME_W-1:0]       issue_sec;
      logic [tdq_pkg::POS_OUT_W-1:0]    position;
      logic [tdq_pkg::COUNT_OUT_W-1:0]  fill;
      logic                             empty;
   } ticket_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [tdq_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [tdq_pkg::REQ_TUSER_W-1:0] req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [tdq_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [tdq_pkg::RSP_TUSER_W-1:0] rsp_tuser;

   ticket_request_type ticket_requests[$];
   ticket_result_type  predicted_results[$];
   logic [tdq_pkg::TICKET_W-1:0] recent_tickets[$];

   // Shadow copy of the deque contents.
   logic [tdq_pkg::TICKET_W-1:0]   shadow_ticket[tdq_pkg::QUEUE_DEPTH];
   logic [tdq_pkg::TIME_W-1:0]     shadow_time[tdq_pkg::QUEUE_DEPTH];
   logic [3:0]            shadow_head = '0;
   logic [4:0]            shadow_held = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int generated = 0;
   int cycle_count = 0;

   ticket_deque_with_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one request to the shadow deque and returns the response it owes.
   function automatic ticket_result_type deque_step(logic [tdq_pkg::OPCODE_W-1:0] op,
                                                    logic [tdq_pkg::TICKET_W-1:0] tk,
                                                    logic [tdq_pkg::TIME_W-1:0] tm);
      ticket_result_type res;
      logic [3:0] slot;
      res = '0;
      res.status = tdq_pkg::ST_OK;
      case (op)
         tdq_pkg::OP_CLEAR: begin
            shadow_held = '0;
         end
         tdq_pkg::OP_PUSH: begin
            if (shadow_held == 5'(tdq_pkg::QUEUE_DEPTH)) begin
               res.status = tdq_pkg::ST_FULL;
            end else begin
               slot = 4'(shadow_head + shadow_held);
               shadow_ticket[slot] = tk;
               shadow_time[slot] = tm;
               shadow_held = shadow_held + 5'd1;
            end
         end
         tdq_pkg::OP_POP_HEAD, tdq_pkg::OP_PEEK: begin
            if (shadow_held == 0) begin
               res.status = tdq_pkg::ST_EMPTY;
            end else begin
               res.entry_valid = 1'b1;
               res.ticket = shadow_ticket[shadow_head];
               res.issue_sec = shadow_time[shadow_head];
               if (op == tdq_pkg::OP_POP_HEAD) begin
                  shadow_head = shadow_head + 4'd1;
                  shadow_held = shadow_held - 5'd1;
               end
            end
         end
         tdq_pkg::OP_POP_TAIL: begin
            if (shadow_held == 0) begin
               res.status = tdq_pkg::ST_EMPTY;
            end else begin
               res.position = 4'(shadow_held - 5'd1);
               slot = shadow_head + res.position;
               res.entry_valid = 1'b1;
               res.ticket = shadow_ticket[slot];
               res.issue_sec = shadow_time[slot];
               shadow_held = shadow_held - 5'd1;
            end
         end
         tdq_pkg::OP_SEARCH: begin
            res.status = tdq_pkg::ST_NOT_FOUND;
            for (int k = 0; k < shadow_held; k++) begin
               slot = 4'(shadow_head + k);
               if (!res.entry_valid && shadow_ticket[slot] == tk) begin
                  res.status = tdq_pkg::ST_OK;
                  res.entry_valid = 1'b1;
                  res.ticket = shadow_ticket[slot];
                  res.issue_sec = shadow_time[slot];
                  res.position = 4'(k);
               end
            end
         end
         default: ;
      endcase
      if (shadow_held == 0) shadow_head = '0;
      res.fill = shadow_held;
      res.empty = (shadow_held == 0);
      return res;
   endfunction

   // Driver: a transfer is predicted at the edge that accepts it.
   always @(posedge clock) begin
      ticket_request_type nxt;
      logic holding;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         holding = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) begin
            predicted_results.push_back(deque_step(req_tuser, req_tdata[15:0],
                                                   req_tdata[32:16]));
         end
         if (!holding) begin
            if (ticket_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = ticket_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= nxt.opcode;
               req_tdata <= {7'b0, nxt.issue_sec, nxt.ticket};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val,
                              inout logic bad);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                  act_val);
         bad = 1'b1;
      end
   endtask

   // Monitor: compares each response transfer with the oldest prediction.
   always @(posedge clock) begin
      ticket_result_type exp_res;
      logic bad;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_results.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual tdata %0h tuser %0h",
                        $time, rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               exp_res = predicted_results.pop_front();
               bad = 1'b0;
               check_field("status", 32'(exp_res.status), 32'(rsp_tuser[1:0]), bad);
               check_field("entry_valid", 32'(exp_res.entry_valid), 32'(rsp_tuser[2]), bad);
               check_field("entry_ticket", 32'(exp_res.ticket), 32'(rsp_tdata[15:0]), bad);
               check_field("entry_time", 32'(exp_res.issue_sec), 32'(rsp_tdata[32:16]), bad);
               check_field("entry_position", 32'(exp_res.position), 32'(rsp_tdata[36:33]),
                           bad);
               check_field("fill_count", 32'(exp_res.fill), 32'(rsp_tdata[41:37]), bad);
               check_field("is_empty", 32'(exp_res.empty), 32'(rsp_tdata[42]), bad);
               if (bad) error_count++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ticket_deque_with_search regression: fail");
         $finish;
      end
   end

   task automatic queue_request(logic [tdq_pkg::OPCODE_W-1:0] op,
                                logic [tdq_pkg::TICKET_W-1:0] tk,
                                logic [tdq_pkg::TIME_W-1:0] tm);
      ticket_request_type item;
      item.opcode = op;
      item.ticket = tk;
      item.issue_sec = tm;
      ticket_requests.push_back(item);
      generated++;
      if (op == tdq_pkg::OP_PUSH) begin
         recent_tickets.push_back(tk);
         if (recent_tickets.size() > tdq_pkg::QUEUE_DEPTH) void'(recent_tickets.pop_front());
      end
   endtask

   // Small values now and then so that duplicate tickets make first-match matter.
   function automatic logic [tdq_pkg::TICKET_W-1:0] pick_ticket();
      if ($urandom_range(4) == 0) return 16'($urandom_range(7));
      return 16'($urandom());
   endfunction

   function automatic logic [tdq_pkg::TICKET_W-1:0] pick_search_ticket();
      if (recent_tickets.size() > 0 && $urandom_range(9) < 7)
         return recent_tickets[$urandom_range(recent_tickets.size() - 1)];
      return pick_ticket();
   endfunction

   task automatic queue_random_op();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) queue_request(tdq_pkg::OP_PUSH, pick_ticket(),
                                   17'($urandom_range(MAX_TIME)));
      else if (pick < 50) queue_request(tdq_pkg::OP_POP_HEAD, pick_ticket(), 17'($urandom()));
      else if (pick < 65) queue_request(tdq_pkg::OP_POP_TAIL, pick_ticket(), 17'($urandom()));
      else if (pick < 75) queue_request(tdq_pkg::OP_PEEK, pick_ticket(), 17'($urandom()));
      else if (pick < 95) queue_request(tdq_pkg::OP_SEARCH, pick_search_ticket(),
                                        17'($urandom()));
      else if (pick < 98) queue_request(tdq_pkg::OP_CLEAR, pick_ticket(), 17'($urandom()));
      else queue_request($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B, pick_ticket(),
                         17'($urandom()));
   endtask

   // Sampled on the falling edge, when the driver and monitor updates have settled.
   task automatic wait_for_drain();
      while (ticket_requests.size() > 0 || predicted_results.size() > 0 || req_tvalid)
         @(negedge clock);
   endtask

   initial begin
      int limit;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty-queue responses, field extremes, first match, and tail positions.
      queue_request(tdq_pkg::OP_CLEAR, 16'h0000, 17'd0);
      queue_request(tdq_pkg::OP_POP_HEAD, 16'hffff, 17'd0);
      queue_request(tdq_pkg::OP_POP_TAIL, 16'h0000, 17'd0);
      queue_request(tdq_pkg::OP_PEEK, 16'h0000, 17'd0);
      queue_request(tdq_pkg::OP_SEARCH, 16'h0000, 17'd0);
      queue_request(tdq_pkg::OP_PUSH, 16'hffff, 17'(MAX_TIME));
      queue_request(tdq_pkg::OP_PUSH, 16'h0000, 17'd0);
      queue_request(tdq_pkg::OP_PUSH, 16'h1234, 17'd65536);
      queue_request(tdq_pkg::OP_PUSH, 16'hffff, 17'd1);
      queue_request(tdq_pkg::OP_PEEK, 16'h0000, 17'd0);
      queue_request(tdq_pkg::OP_SEARCH, 16'hffff, 17'd0);
      queue_request(tdq_pkg::OP_SEARCH, 16'h0000, 17'd0);
      queue_request(tdq_pkg::OP_SEARCH, 16'h1234, 17'd0);
      queue_request(tdq_pkg::OP_SEARCH, 16'h7777, 17'd0);
      queue_request(tdq_pkg::OP_POP_TAIL, 16'h0000, 17'd0);
      queue_request(OP_SPARE_A, 16'hffff, 17'h1ffff);
      queue_request(OP_SPARE_B, 16'h0000, 17'd0);
      queue_request(tdq_pkg::OP_POP_HEAD, 16'h0000, 17'd0);
      queue_request(tdq_pkg::OP_POP_TAIL, 16'h0000, 17'd0);
      queue_request(tdq_pkg::OP_POP_HEAD, 16'h0000, 17'd0);
      queue_request(tdq_pkg::OP_PUSH, 16'h00aa, 17'd500);
      queue_request(tdq_pkg::OP_CLEAR, 16'h0000, 17'd0);

      for (int phase = 0; phase < 4; phase++) begin
         wait_for_drain();
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         limit = generated + PHASE_ITEMS;
         while (generated < limit) begin
            case ($urandom_range(9))
               0, 1, 2, 3: repeat (8) queue_random_op();
               4, 5: begin
                  // Fill bursts run past the depth often enough to hit a full queue.
                  repeat ($urandom_range(20, 8))
                     queue_request(tdq_pkg::OP_PUSH, pick_ticket(),
                                   17'($urandom_range(MAX_TIME)));
                  repeat (2) queue_request(tdq_pkg::OP_SEARCH, pick_search_ticket(),
                                           17'($urandom()));
               end
               6, 7: begin
                  repeat ($urandom_range(18, 4))
                     queue_request($urandom_range(1) ? tdq_pkg::OP_POP_HEAD
                                                     : tdq_pkg::OP_POP_TAIL,
                                   pick_ticket(), 17'($urandom()));
               end
               8: repeat (6) queue_request(tdq_pkg::OP_SEARCH, pick_search_ticket(),
                                           17'($urandom()));
               default: begin
                  queue_request(tdq_pkg::OP_CLEAR, pick_ticket(), 17'($urandom()));
                  queue_request(tdq_pkg::OP_PEEK, pick_ticket(), 17'($urandom()));
                  queue_request($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B, pick_ticket(),
                                17'($urandom()));
               end
            endcase
         end
      end

      wait_for_drain();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("ticket_deque_with_search regression: pass");
      end else begin
         $display("ticket_deque_with_search regression: fail");
      end
      $finish;
   end

endmodule
